### src/kslpd_pkg.sv
// kslpd_pkg: shared types, register indexes and defaults for the key press detector
// used by kslpd_lane, kslpd_out_buf and key_short_long_press_detector
package kslpd_pkg;

  // fixed field widths
  localparam int unsigned KeyBits   = 8;
  localparam int unsigned RegBits   = 16;
  localparam int unsigned IndexBits = 2;

  // parameter defaults
  localparam int unsigned NumKeysDefault    = 8;
  localparam int unsigned TimerWidthDefault = 16;

  // register reset values
  localparam logic [RegBits-1:0] LongTicksReset = 16'd5000;
  localparam logic [RegBits-1:0] DebTicksReset  = 16'd50;
  localparam logic [KeyBits-1:0] KeyEnableReset = 8'hFF;

  // register indexes
  localparam logic [IndexBits-1:0] RegLongTicks = 2'd0;
  localparam logic [IndexBits-1:0] RegDebTicks  = 2'd1;
  localparam logic [IndexBits-1:0] RegKeyEnable = 2'd2;

  // edge a lane is waiting for
  typedef enum logic [1:0] {
    WATCH_NONE = 2'd0,
    WATCH_FALL = 2'd1,
    WATCH_RISE = 2'd2
  } watch_e;

  // timer settings seen by every lane
  typedef struct packed {
    logic [RegBits-1:0] long_ticks;
    logic [RegBits-1:0] deb_ticks;
  } lane_cfg_t;

  // per-lane findings for one sample
  typedef struct packed {
    logic short_press;
    logic long_press;
  } lane_res_t;

  // one result item
  typedef struct packed {
    logic [KeyBits-1:0] long_press;
    logic [KeyBits-1:0] short_press;
  } result_t;

endpackage

### src/kslpd_lane.sv
// kslpd_lane: per-key controller with long-press and debounce timers
// depends on kslpd_pkg
module kslpd_lane #(
  parameter int unsigned TIMER_WIDTH = kslpd_pkg::TimerWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 enable_i,
  input  logic                 level_i,
  input  logic                 tick_i,
  input  kslpd_pkg::lane_cfg_t cfg_i,
  output kslpd_pkg::lane_res_t res_o
);
  import kslpd_pkg::*;

  localparam logic [TIMER_WIDTH-1:0] CntOne = TIMER_WIDTH'(1);

  logic                   released_q, released_d;
  watch_e                 watch_q, watch_d;
  logic                   prev_q;
  logic [TIMER_WIDTH-1:0] long_cnt_q, long_cnt_d;
  logic                   long_act_q, long_act_d;
  logic [TIMER_WIDTH-1:0] deb_cnt_q, deb_cnt_d;
  logic                   deb_act_q, deb_act_d;
  logic                   fell, rose, hit;

  // next state for one sample
  always_comb begin
    released_d = released_q;
    watch_d    = watch_q;
    long_cnt_d = long_cnt_q;
    long_act_d = long_act_q;
    deb_cnt_d  = deb_cnt_q;
    deb_act_d  = deb_act_q;
    res_o      = '0;
    fell       = prev_q && !level_i;
    rose       = !prev_q && level_i;
    hit        = 1'b0;

    if (enable_i) begin
      // long timer counts first
      if (tick_i && long_act_q) begin
        if (long_cnt_q <= CntOne) begin
          long_cnt_d = '0;
          long_act_d = 1'b0;
          res_o.long_press = !level_i;
        end else begin
          long_cnt_d = long_cnt_q - CntOne;
        end
      end

      // debounce expiry confirms the release or rearms rise watching
      if (tick_i && deb_act_q) begin
        if (deb_cnt_q <= CntOne) begin
          deb_cnt_d = '0;
          deb_act_d = 1'b0;
          if (level_i) begin
            long_act_d        = 1'b0;
            long_cnt_d        = '0;
            released_d        = 1'b1;
            watch_d           = WATCH_FALL;
            res_o.short_press = 1'b1;
          end else begin
            watch_d = WATCH_RISE;
          end
        end else begin
          deb_cnt_d = deb_cnt_q - CntOne;
        end
      end

      // edge check against what is being watched
      case (watch_d)
        WATCH_FALL: hit = fell;
        WATCH_RISE: hit = rose;
        default:    hit = 1'b0;
      endcase

      if (hit) begin
        if (released_d) begin
          long_cnt_d = TIMER_WIDTH'(cfg_i.long_ticks);
          long_act_d = 1'b1;
          released_d = 1'b0;
          watch_d    = WATCH_RISE;
        end else begin
          watch_d   = WATCH_NONE;
          deb_cnt_d = TIMER_WIDTH'(cfg_i.deb_ticks);
          deb_act_d = 1'b1;
        end
      end
    end
  end

  // lane state, updated once per accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      released_q <= 1'b1;
      watch_q    <= WATCH_FALL;
      prev_q     <= 1'b1;
      long_cnt_q <= '0;
      long_act_q <= 1'b0;
      deb_cnt_q  <= '0;
      deb_act_q  <= 1'b0;
    end else if (step_i) begin
      released_q <= released_d;
      watch_q    <= watch_d;
      prev_q     <= level_i;
      long_cnt_q <= long_cnt_d;
      long_act_q <= long_act_d;
      deb_cnt_q  <= deb_cnt_d;
      deb_act_q  <= deb_act_d;
    end
  end

endmodule

### src/kslpd_out_buf.sv
// kslpd_out_buf: output register with a skid entry so the input side can keep flowing
// depends on kslpd_pkg
module kslpd_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  kslpd_pkg::result_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output kslpd_pkg::result_t data_o
);
  import kslpd_pkg::*;

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    push, pop;

  assign ready_o = !skid_valid_q;
  assign push    = valid_i && ready_o;
  assign pop     = out_valid_q && ready_i;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  // control: main register refills from skid first, then from the input
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (push) begin
      skid_q <= data_i;
    end
  end

endmodule

### src/key_short_long_press_detector.sv
// key_short_long_press_detector: top level with config registers, key lanes and merge
// depends on kslpd_pkg, kslpd_lane, kslpd_out_buf
// output: an accepted sample's result is registered, or held in the skid entry on a stall
// throughput: one sample per cycle while the skid entry is empty, skid entry decouples
// reset: asynchronous, active low; registers take 5000 / 50 / all keys enabled,
// every lane returns to released and watching for a falling edge
module key_short_long_press_detector #(
  parameter int unsigned NUM_KEYS    = kslpd_pkg::NumKeysDefault,
  parameter int unsigned TIMER_WIDTH = kslpd_pkg::TimerWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [kslpd_pkg::IndexBits-1:0] cfg_index_i,
  input  logic [kslpd_pkg::RegBits-1:0] cfg_data_i,
  // sample stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] pin_levels
  input  logic                          s_axis_tuser,  // [0] tick
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata   // [7:0] short_press, [15:8] long_press
);
  import kslpd_pkg::*;

  // keys beyond the pin field have no pin and stay idle
  localparam int unsigned NumLanes = (NUM_KEYS < KeyBits) ? NUM_KEYS : KeyBits;

  logic [RegBits-1:0] long_ticks_q;
  logic [RegBits-1:0] deb_ticks_q;
  logic [KeyBits-1:0] key_en_q;
  lane_cfg_t          lane_cfg;
  lane_res_t          lane_res [NumLanes];
  result_t            merged;
  result_t            out_data;
  logic               step;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q <= LongTicksReset;
      deb_ticks_q  <= DebTicksReset;
      key_en_q     <= KeyEnableReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegLongTicks: long_ticks_q <= cfg_data_i;
        RegDebTicks:  deb_ticks_q  <= cfg_data_i;
        RegKeyEnable: key_en_q     <= cfg_data_i[KeyBits-1:0];
        default: ;
      endcase
    end
  end

  assign lane_cfg.long_ticks = long_ticks_q;
  assign lane_cfg.deb_ticks  = deb_ticks_q;
  assign step                = s_axis_tvalid && s_axis_tready;

  // one controller per key that has a pin
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    kslpd_lane #(
      .TIMER_WIDTH(TIMER_WIDTH)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (step),
      .enable_i(key_en_q[g]),
      .level_i (s_axis_tdata[g]),
      .tick_i  (s_axis_tuser),
      .cfg_i   (lane_cfg),
      .res_o   (lane_res[g])
    );
  end

  // merge lane findings into one result item
  always_comb begin
    merged = '0;
    for (int i = 0; i < NumLanes; i++) begin
      merged.short_press[i] = lane_res[i].short_press;
      merged.long_press[i]  = lane_res[i].long_press;
    end
  end

  kslpd_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_axis_tvalid),
    .ready_o(s_axis_tready),
    .data_i (merged),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (out_data)
  );

  assign m_axis_tdata = {out_data.long_press, out_data.short_press};

endmodule

### tb/sv/key_short_long_press_detector_tb.sv
// key_short_long_press_detector_tb: self-checking bench for the key press detector
// depends on kslpd_pkg and key_short_long_press_detector; per-lane press model,
// random idling on both streams, register writes between phases
`timescale 1ns / 1ps

module key_short_long_press_detector_tb;
  import kslpd_pkg::*;

  localparam int unsigned       NumLanes   = 8;
  localparam int unsigned       CycleLimit = 200000;
  localparam logic [IndexBits-1:0] RegSpare = 2'd3;  // unmapped index, write is ignored

  typedef struct packed {
    logic [KeyBits-1:0] pins;
    logic               tick;
  } sample_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [IndexBits-1:0] cfg_index_i = '0;
  logic [RegBits-1:0]   cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '1;   // [7:0] pin_levels
  logic                 s_axis_tuser = 1'b0; // [0] tick
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;        // [7:0] short_press, [15:8] long_press

  // stimulus and scoreboard
  sample_t sample_q[$];
  result_t press_q[$];
  int      mismatch_cnt = 0;
  int      cycle_cnt = 0;
  logic    req_taken = 1'b0;
  logic    calm = 1'b0;
  logic    stall_phase = 1'b0;
  logic    stall_done = 1'b0;
  int      hold_cnt = 0;

  // press model state
  logic [RegBits-1:0] long_ticks_m;
  logic [RegBits-1:0] deb_ticks_m;
  logic [KeyBits-1:0] key_en_m;
  logic               released_m [NumLanes];
  watch_e             watch_m    [NumLanes];
  logic               prev_lvl_m [NumLanes];
  logic [RegBits-1:0] long_cnt_m [NumLanes];
  logic               long_on_m  [NumLanes];
  logic [RegBits-1:0] deb_cnt_m  [NumLanes];
  logic               deb_on_m   [NumLanes];

  // random key generator state
  logic [KeyBits-1:0] key_lvl = '1;
  int                 run_left [NumLanes];

  key_short_long_press_detector u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("key_short_long_press_detector verification failed");
      $finish;
    end
  end

  // one sample through every lane: timers first, then edge detection
  function automatic result_t lanes_step(logic [KeyBits-1:0] pins, logic tick);
    result_t r;
    logic    lvl;
    logic    fell;
    logic    rose;
    r = '0;
    for (int k = 0; k < NumLanes; k++) begin
      lvl = pins[k];
      if (key_en_m[k]) begin
        // long timer, reported only while the key is still down
        if (tick && long_on_m[k]) begin
          if (long_cnt_m[k] <= 1) begin
            long_cnt_m[k] = '0;
            long_on_m[k]  = 1'b0;
            if (!lvl) r.long_press[k] = 1'b1;
          end else begin
            long_cnt_m[k] = long_cnt_m[k] - 1'b1;
          end
        end
        // debounce timer confirms or rejects the release
        if (tick && deb_on_m[k]) begin
          if (deb_cnt_m[k] <= 1) begin
            deb_cnt_m[k] = '0;
            deb_on_m[k]  = 1'b0;
            if (lvl) begin
              long_on_m[k]  = 1'b0;
              long_cnt_m[k] = '0;
              released_m[k] = 1'b1;
              watch_m[k]    = WATCH_FALL;
              r.short_press[k] = 1'b1;
            end else begin
              watch_m[k] = WATCH_RISE;
            end
          end else begin
            deb_cnt_m[k] = deb_cnt_m[k] - 1'b1;
          end
        end
        // watched edge arms the next timer
        fell = prev_lvl_m[k] && !lvl;
        rose = !prev_lvl_m[k] && lvl;
        if ((watch_m[k] == WATCH_FALL && fell) || (watch_m[k] == WATCH_RISE && rose)) begin
          watch_m[k] = WATCH_NONE;
          if (released_m[k]) begin
            long_cnt_m[k] = long_ticks_m;
            long_on_m[k]  = 1'b1;
            released_m[k] = 1'b0;
            watch_m[k]    = WATCH_RISE;
          end else begin
            deb_cnt_m[k] = deb_ticks_m;
            deb_on_m[k]  = 1'b1;
          end
        end
      end
      prev_lvl_m[k] = lvl;
    end
    return r;
  endfunction

  // sample driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (sample_q.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample_q[0].pins;
        s_axis_tuser  <= sample_q[0].tick;
        void'(sample_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);
        s_axis_tuser  <= 1'($urandom);
      end
    end
  end

  // result receiver, with one long hold-off in the pressure phase
  always @(negedge clk_i) begin
    if (stall_phase && !stall_done) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt + 1;
      if (hold_cnt == 299) stall_done <= 1'b1;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 24);
    end
  end

  // monitor: check results, then predict accepted requests and register writes
  always @(posedge clk_i) begin
    result_t got_res;
    result_t want_res;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = m_axis_tdata;
        if (press_q.size() == 0) begin
          $error("result with no request pending: %h", m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want_res = press_q.pop_front();
          if (got_res.short_press !== want_res.short_press) begin
            $error("short_press expected %h actual %h", want_res.short_press,
                   got_res.short_press);
            mismatch_cnt++;
          end
          if (got_res.long_press !== want_res.long_press) begin
            $error("long_press expected %h actual %h", want_res.long_press,
                   got_res.long_press);
            mismatch_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        press_q.push_back(lanes_step(s_axis_tdata, s_axis_tuser));
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegLongTicks: long_ticks_m = cfg_data_i;
          RegDebTicks:  deb_ticks_m  = cfg_data_i;
          RegKeyEnable: key_en_m     = cfg_data_i[KeyBits-1:0];
          default: ;
        endcase
      end
    end
    req_taken <= s_axis_tvalid && s_axis_tready;
  end

  task automatic push_sample(logic [KeyBits-1:0] pins, logic tick);
    sample_t s;
    s.pins = pins;
    s.tick = tick;
    sample_q.push_back(s);
  endtask

  // press/release runs per key with bounce, plus some fully random samples
  task automatic push_presses(int n, int tick_pct, int noise_pct);
    logic [KeyBits-1:0] pins;
    int                 max_run;
    max_run = 3 * ((long_ticks_m > deb_ticks_m) ? long_ticks_m : deb_ticks_m) + 8;
    if (max_run > 150) max_run = 150;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < NumLanes; k++) begin
        if (run_left[k] <= 0) begin
          key_lvl[k]  = ~key_lvl[k];
          run_left[k] = $urandom_range(max_run, 1);
        end
        run_left[k]--;
      end
      pins = key_lvl;
      // contact bounce for one sample
      for (int k = 0; k < NumLanes; k++) begin
        if ($urandom_range(99) < 4) pins[k] = ~pins[k];
      end
      if ($urandom_range(99) < noise_pct) pins = KeyBits'($urandom);
      push_sample(pins, $urandom_range(99) < tick_pct);
    end
  endtask

  // wait until every request is sent and every result has come back
  task automatic drain();
    while (sample_q.size() != 0 || s_axis_tvalid || press_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IndexBits-1:0] idx, logic [RegBits-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_data_i  <= RegBits'($urandom);
  endtask

  // stimulus
  initial begin
    long_ticks_m = LongTicksReset;
    deb_ticks_m  = DebTicksReset;
    key_en_m     = KeyEnableReset;
    for (int k = 0; k < NumLanes; k++) begin
      released_m[k] = 1'b1;
      watch_m[k]    = WATCH_FALL;
      prev_lvl_m[k] = 1'b1;
      long_cnt_m[k] = '0;
      long_on_m[k]  = 1'b0;
      deb_cnt_m[k]  = '0;
      deb_on_m[k]   = 1'b0;
      run_left[k]   = 2 * k + 1;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values of the timers, ticks on every sample
    push_presses(100, 100, 5);
    drain();

    // directed: short timers, all keys together
    write_reg(RegLongTicks, 16'd3);
    write_reg(RegDebTicks, 16'd2);
    push_sample(8'hFF, 1'b0);
    push_sample(8'hFF, 1'b1);
    push_sample(8'h00, 1'b0);  // press all, long timer armed
    push_sample(8'h00, 1'b1);
    push_sample(8'h00, 1'b1);
    push_sample(8'h00, 1'b1);  // long press on all keys
    push_sample(8'h55, 1'b0);  // release half, debounce armed
    push_sample(8'h00, 1'b0);  // bounce back low, edge not watched
    push_sample(8'h55, 1'b1);
    push_sample(8'h55, 1'b1);  // release confirmed
    push_sample(8'hFF, 1'b1);  // release the rest
    push_sample(8'h0F, 1'b1);  // low again during debounce
    push_sample(8'h0F, 1'b1);  // debounce expires low, back to watching rise
    push_sample(8'hFF, 1'b0);
    push_sample(8'hFF, 1'b1);
    push_sample(8'hFF, 1'b1);
    push_sample(8'h00, 1'b1);  // press and tick in one sample
    push_sample(8'hFE, 1'b1);
    push_sample(8'hFE, 1'b1);
    push_sample(8'hFF, 1'b1);
    push_sample(8'hFF, 1'b1);
    push_sample(8'hFF, 1'b1);
    drain();

    write_reg(RegLongTicks, 16'd4);
    push_presses(150, 50, 10);
    drain();

    write_reg(RegLongTicks, 16'd1);
    write_reg(RegDebTicks, 16'd1);
    push_presses(100, 70, 10);
    drain();

    // zero timer loads expire on the first tick
    write_reg(RegLongTicks, 16'd0);
    write_reg(RegDebTicks, 16'd0);
    push_presses(80, 60, 10);
    drain();

    // partial enable, timer and watch state of disabled lanes is held
    write_reg(RegLongTicks, 16'd6);
    write_reg(RegDebTicks, 16'd3);
    write_reg(RegKeyEnable, 16'h00A5);
    push_presses(120, 60, 10);
    drain();

    // unmapped index must not touch any register
    write_reg(RegSpare, 16'h0002);
    write_reg(RegKeyEnable, 16'h0000);
    push_presses(60, 60, 10);
    drain();

    // receiver holds off while the sender keeps offering
    write_reg(RegLongTicks, 16'd10);
    write_reg(RegDebTicks, 16'd4);
    write_reg(RegKeyEnable, 16'h005A);
    stall_phase = 1'b1;
    push_presses(150, 60, 10);
    drain();
    stall_phase = 1'b0;

    // upper extremes
    write_reg(RegLongTicks, 16'hFFFF);
    write_reg(RegDebTicks, 16'hFFFF);
    write_reg(RegKeyEnable, 16'h00FF);
    push_presses(40, 80, 10);
    drain();

    // no idling, then the sender pauses for the drain and resumes
    write_reg(RegLongTicks, 16'd2);
    write_reg(RegDebTicks, 16'd5);
    calm = 1'b1;
    push_presses(150, 50, 10);
    drain();
    calm = 1'b0;
    push_presses(150, 50, 10);
    drain();

    repeat (10) @(posedge clk_i);
    if (press_q.size() != 0) begin
      $error("%0d results never arrived", press_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("key_short_long_press_detector verification clean");
    end else begin
      $display("key_short_long_press_detector verification failed");
    end
    $finish;
  end

endmodule
